@@ design/kis_pkg.sv @@
// package for the keyed insertion stack: sizes, codes and controller/datapath interface types
`default_nettype none

package kis_pkg;

   // capacity and derived widths
   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // fixed field widths
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int KEY_W    = 8;
   localparam int VAL_W    = 8;
   localparam int STAT_W   = 2;
   localparam int OFFS_W   = 4;
   localparam int FILL_W   = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      REQ_PEEK = 2'd0,
      REQ_PUSH = 2'd1,
      REQ_POP  = 2'd2,
      REQ_FIND = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_UP_RD,
      S_UP_WR,
      S_DOWN_RD,
      S_DOWN_WR,
      S_DONE
   } state_type;

   // pointer updates
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC,
      PTR_COUNT
   } ptr_op_type;

   // memory read selection
   typedef enum logic [2:0] {
      RD_NONE,
      RD_PEEK,
      RD_PTR,
      RD_PTR_DN,
      RD_PTR_UP
   } rd_op_type;

   // memory write selection, always at the pointer
   typedef enum logic [1:0] {
      WR_NONE,
      WR_VALUE,
      WR_SHIFT,
      WR_NEW
   } wr_op_type;

   // entry count updates
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // reported offset updates
   typedef enum logic [1:0] {
      OFFS_HOLD,
      OFFS_HIT,
      OFFS_POS
   } offs_op_type;

   // controller to datapath
   typedef struct packed {
      logic        load_req;
      ptr_op_type  ptr_op;
      rd_op_type   rd_op;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      logic        set_status;
      status_type  status_code;
      offs_op_type offs_op;
      logic        load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      req_kind_type req_kind;
      logic         key_hit;
      logic         search_end;
      logic         full;
      logic         range_err;
      logic         at_insert;
      logic         down_end;
      logic         rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ design/kis_datapath.sv @@
// datapath of the keyed insertion stack: entry memories, pointer, count and result register
`default_nettype none

module kis_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kis_pkg::cmd_type               cmd,
   output kis_pkg::stat_type                   stat,
   // position, entry_key, entry_value from bit 0 up, zero padded
   input  wire logic [kis_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [kis_pkg::KIND_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // found_offset, peek_value, fill_count from bit 0 up, zero padded
   output logic [kis_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [kis_pkg::STAT_W-1:0]          rsp_tuser
);

   localparam int IDX_W = kis_pkg::IDX_W;
   localparam int CNT_W = kis_pkg::CNT_W;
   localparam int CMP_W = kis_pkg::CMP_W;
   localparam int POS_W = kis_pkg::POS_W;
   localparam int KEY_W = kis_pkg::KEY_W;
   localparam int VAL_W = kis_pkg::VAL_W;

   // entry memories, index 0 is the bottom
   logic [KEY_W-1:0] key_mem_ff [kis_pkg::STACK_DEPTH];
   logic [VAL_W-1:0] val_mem_ff [kis_pkg::STACK_DEPTH];
   logic [KEY_W-1:0] rd_key_ff;
   logic [VAL_W-1:0] rd_val_ff;

   // latched request
   kis_pkg::req_kind_type kind_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VAL_W-1:0]      val_ff;

   // walk state
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   kis_pkg::status_type status_ff;
   logic [CMP_W-1:0] offs_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   kis_pkg::status_type          rsp_status_ff;
   logic [kis_pkg::OFFS_W-1:0]   rsp_offs_ff;
   logic [VAL_W-1:0]             rsp_peek_ff;
   logic [kis_pkg::FILL_W-1:0]   rsp_fill_ff;

   // widened operands for offset arithmetic
   logic [CMP_W-1:0] ptr_w, count_w, pos_w;
   logic [CMP_W-1:0] peek_addr_w, hit_offs_w;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [KEY_W-1:0] wr_key;
   logic [VAL_W-1:0] wr_val;
   logic             wr_key_en;
   logic             peek_hit;

   assign ptr_w       = CMP_W'(ptr_ff);
   assign count_w     = CMP_W'(count_ff);
   assign pos_w       = CMP_W'(pos_ff);
   assign peek_addr_w = count_w - CMP_W'(1) - pos_w;
   assign hit_offs_w  = count_w - CMP_W'(1) - ptr_w;
   assign peek_hit    = (kind_ff == kis_pkg::REQ_PEEK) && (pos_w < count_w);

   // status toward the controller
   always_comb begin
      stat.req_kind   = kind_ff;
      stat.key_hit    = (rd_key_ff == key_ff);
      stat.search_end = (ptr_ff >= count_ff);
      stat.full       = (count_w >= CMP_W'(kis_pkg::STACK_DEPTH));
      stat.range_err  = (pos_w > count_w);
      stat.at_insert  = ((ptr_w + pos_w) == count_w);
      stat.down_end   = ((ptr_w + CMP_W'(1)) >= count_w);
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   // memory address and data selection
   always_comb begin
      rd_en   = (cmd.rd_op != kis_pkg::RD_NONE);
      case (cmd.rd_op)
         kis_pkg::RD_PEEK:   rd_addr = peek_addr_w[IDX_W-1:0];
         kis_pkg::RD_PTR_DN: rd_addr = IDX_W'(ptr_ff - CNT_W'(1));
         kis_pkg::RD_PTR_UP: rd_addr = IDX_W'(ptr_ff + CNT_W'(1));
         default:            rd_addr = ptr_ff[IDX_W-1:0];
      endcase
      wr_en     = (cmd.wr_op != kis_pkg::WR_NONE);
      wr_key_en = cmd.wr_op inside {kis_pkg::WR_SHIFT, kis_pkg::WR_NEW};
      wr_addr   = ptr_ff[IDX_W-1:0];
      case (cmd.wr_op)
         kis_pkg::WR_SHIFT: begin
            wr_key = rd_key_ff;
            wr_val = rd_val_ff;
         end
         default: begin
            wr_key = key_ff;
            wr_val = val_ff;
         end
      endcase
   end

   // entry memories with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem_ff[wr_addr] <= wr_val;
         if (wr_key_en) begin
            key_mem_ff[wr_addr] <= wr_key;
         end
      end
      if (rd_en) begin
         rd_key_ff <= key_mem_ff[rd_addr];
         rd_val_ff <= val_mem_ff[rd_addr];
      end
   end

   // pointer and count next values
   always_comb begin
      case (cmd.ptr_op)
         kis_pkg::PTR_ZERO:  ptr_in = '0;
         kis_pkg::PTR_INC:   ptr_in = ptr_ff + CNT_W'(1);
         kis_pkg::PTR_DEC:   ptr_in = ptr_ff - CNT_W'(1);
         kis_pkg::PTR_COUNT: ptr_in = count_ff;
         default:            ptr_in = ptr_ff;
      endcase
      case (cmd.cnt_op)
         kis_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
         kis_pkg::CNT_DEC: count_in = count_ff - CNT_W'(1);
         default:          count_in = count_ff;
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request latch and walk registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_req) begin
         kind_ff   <= kis_pkg::req_kind_type'(req_tuser);
         pos_ff    <= req_tdata[POS_W-1:0];
         key_ff    <= req_tdata[POS_W +: KEY_W];
         val_ff    <= req_tdata[POS_W + KEY_W +: VAL_W];
         status_ff <= kis_pkg::ST_OK;
         offs_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         case (cmd.offs_op)
            kis_pkg::OFFS_HIT: offs_ff <= hit_offs_w;
            kis_pkg::OFFS_POS: offs_ff <= pos_w;
            default:           offs_ff <= offs_ff;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_offs_ff   <= offs_ff[kis_pkg::OFFS_W-1:0];
         rsp_peek_ff   <= peek_hit ? rd_val_ff : '0;
         rsp_fill_ff   <= count_w[kis_pkg::FILL_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_fill_ff, rsp_peek_ff, rsp_offs_ff};

endmodule

`default_nettype wire

@@ design/kis_ctrl.sv @@
// controller of the keyed insertion stack: sequences search, shift and result steps
`default_nettype none

module kis_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire kis_pkg::stat_type stat,
   output kis_pkg::cmd_type       cmd
);

   kis_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kis_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         kis_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               cmd.ptr_op   = kis_pkg::PTR_ZERO;
               state_in     = kis_pkg::S_SEARCH_RD;
            end
         end
         // peek read, or next key read, or miss handling: not found, full, range error or start of the insert
         kis_pkg::S_SEARCH_RD: begin
            if (stat.req_kind == kis_pkg::REQ_PEEK) begin
               cmd.rd_op = kis_pkg::RD_PEEK;
               state_in  = kis_pkg::S_DONE;
            end else if (!stat.search_end) begin
               cmd.rd_op = kis_pkg::RD_PTR;
               state_in  = kis_pkg::S_SEARCH_CMP;
            end else if (stat.req_kind != kis_pkg::REQ_PUSH) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = kis_pkg::ST_NOT_FOUND;
               state_in        = kis_pkg::S_DONE;
            end else if (stat.full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = kis_pkg::ST_FULL;
               state_in        = kis_pkg::S_DONE;
            end else if (stat.range_err) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = kis_pkg::ST_RANGE;
               state_in        = kis_pkg::S_DONE;
            end else begin
               cmd.ptr_op  = kis_pkg::PTR_COUNT;
               cmd.offs_op = kis_pkg::OFFS_POS;
               state_in    = kis_pkg::S_UP_RD;
            end
         end
         // compare the key read at the pointer
         kis_pkg::S_SEARCH_CMP: begin
            if (stat.key_hit) begin
               cmd.offs_op = kis_pkg::OFFS_HIT;
               case (stat.req_kind)
                  kis_pkg::REQ_PUSH: begin
                     cmd.wr_op = kis_pkg::WR_VALUE;
                     state_in  = kis_pkg::S_DONE;
                  end
                  kis_pkg::REQ_POP: begin
                     state_in = kis_pkg::S_DOWN_RD;
                  end
                  default: begin
                     state_in = kis_pkg::S_DONE;
                  end
               endcase
            end else begin
               cmd.ptr_op = kis_pkg::PTR_INC;
               state_in   = kis_pkg::S_SEARCH_RD;
            end
         end
         // open a slot by moving entries up
         kis_pkg::S_UP_RD: begin
            if (stat.at_insert) begin
               cmd.wr_op  = kis_pkg::WR_NEW;
               cmd.cnt_op = kis_pkg::CNT_INC;
               state_in   = kis_pkg::S_DONE;
            end else begin
               cmd.rd_op = kis_pkg::RD_PTR_DN;
               state_in  = kis_pkg::S_UP_WR;
            end
         end
         kis_pkg::S_UP_WR: begin
            cmd.wr_op  = kis_pkg::WR_SHIFT;
            cmd.ptr_op = kis_pkg::PTR_DEC;
            state_in   = kis_pkg::S_UP_RD;
         end
         // close the gap by moving entries down
         kis_pkg::S_DOWN_RD: begin
            if (stat.down_end) begin
               cmd.cnt_op = kis_pkg::CNT_DEC;
               state_in   = kis_pkg::S_DONE;
            end else begin
               cmd.rd_op = kis_pkg::RD_PTR_UP;
               state_in  = kis_pkg::S_DOWN_WR;
            end
         end
         kis_pkg::S_DOWN_WR: begin
            cmd.wr_op  = kis_pkg::WR_SHIFT;
            cmd.ptr_op = kis_pkg::PTR_INC;
            state_in   = kis_pkg::S_DOWN_RD;
         end
         // hand the result over once the output register is free
         kis_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = kis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kis_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/keyed_insertion_stack.sv @@
// top level of the keyed insertion stack: controller and datapath
// one request at a time; a peek does a registered read of its entry and then loads the result
// key search reads and then compares one entry at a time, from the bottom up
// each shift of an entry up (push) or down (pop) is a read step followed by a write step
// worst case is push of a new key: a search of every entry, then a shift of every entry up
// synchronous reset empties the stack and drops any pending result
`default_nettype none

module keyed_insertion_stack (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // position, entry_key, entry_value from bit 0 up, zero padded
   input  wire logic [kis_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [kis_pkg::KIND_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // found_offset, peek_value, fill_count from bit 0 up, zero padded
   output logic [kis_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [kis_pkg::STAT_W-1:0]          rsp_tuser
);

   kis_pkg::cmd_type  cmd;
   kis_pkg::stat_type stat;

   // sequencer
   kis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage and result
   kis_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("result register overwritten");

   // failed requests report offset zero
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != kis_pkg::ST_OK)) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("nonzero offset on failed request");

   // reported fill never exceeds capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:12] <= 5'(kis_pkg::STACK_DEPTH)))
      else $error("fill count above capacity");

   // memory writes happen only while a request is in progress
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != kis_pkg::WR_NONE) |-> !req_tready)
      else $error("entry write while idle");
`endif

endmodule

`default_nettype wire
